// File: src/binary_min_heap_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the binary min-heap checker
// Both macros sample on i_clk and are disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BINARY_MIN_HEAP_TOP_ASSERT_SVH
`define BINARY_MIN_HEAP_TOP_ASSERT_SVH

// same-cycle implication
`define BMH_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("binary min-heap check failed");

// next-cycle implication
`define BMH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("binary min-heap check failed");

`endif

// File: src/bmh_pkg.sv
// ----------------------------------------------------------------------------
// bmh_pkg
// Types and codes shared by the binary min-heap modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bmh_pkg;

    localparam int KEY_W = 32;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_POP_LD,
        S_DN_RD,
        S_DN_CMP,
        S_PEEK_LD
    } t_state;

    // one result, as raised by the sequencer
    typedef struct packed {
        logic                    valid;
        logic signed [KEY_W-1:0] key;
        t_status                 status;
    } t_rsp;

endpackage

`default_nettype wire

// File: src/bmh_ram.sv
// ----------------------------------------------------------------------------
// bmh_ram
// Key store: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bmh_ram
    import bmh_pkg::*;
#(
    parameter  int DEPTH = 1024,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_we,
    input  wire logic [AW-1:0]           i_waddr,
    input  wire logic signed [KEY_W-1:0] i_wdata,
    input  wire logic [AW-1:0]           i_raddr_a,
    input  wire logic [AW-1:0]           i_raddr_b,
    output logic signed [KEY_W-1:0]      o_rdata_a,
    output logic signed [KEY_W-1:0]      o_rdata_b
);

    logic signed [KEY_W-1:0] mem [DEPTH];
    logic signed [KEY_W-1:0] r_rdata_a;
    logic signed [KEY_W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata_a <= mem[i_raddr_a];
        r_rdata_b <= mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

// File: src/bmh_ctrl.sv
// ----------------------------------------------------------------------------
// bmh_ctrl
// Sequencer for push, pop and peek: holds the entry count and walks the
// sift loops over the key store, keeping the moving key in a register.
// ----------------------------------------------------------------------------
`default_nettype none

module bmh_ctrl
    import bmh_pkg::*;
#(
    parameter  int CAPACITY = 1024,
    localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW       = $clog2(CAPACITY + 1),
    localparam int IW       = AW + 2
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic [1:0]              i_operation,
    input  wire logic signed [KEY_W-1:0] i_key_in,
    output logic                         o_busy,
    output logic                         o_mem_we,
    output logic [AW-1:0]                o_mem_waddr,
    output logic signed [KEY_W-1:0]      o_mem_wdata,
    output logic [AW-1:0]                o_mem_raddr_a,
    output logic [AW-1:0]                o_mem_raddr_b,
    input  wire logic signed [KEY_W-1:0] i_mem_rdata_a,
    input  wire logic signed [KEY_W-1:0] i_mem_rdata_b,
    output t_rsp                         o_rsp,
    output logic [CW-1:0]                o_count_next
);

    t_state                  r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [IW-1:0]           r_pos,   n_pos;
    logic signed [KEY_W-1:0] r_key,   n_key;
    logic signed [KEY_W-1:0] r_root,  n_root;

    logic [IW-1:0]           w_cnt_x;
    logic [IW-1:0]           w_up;
    logic [IW-1:0]           w_kid;
    logic [IW-1:0]           w_kid_r;
    logic [CW-1:0]           w_last;
    logic                    w_right_ok;
    logic                    w_take_r;
    logic signed [KEY_W-1:0] w_child;
    logic [IW-1:0]           w_child_idx;

    assign w_cnt_x     = {{(IW-CW){1'b0}}, r_count};
    assign w_up        = (r_pos - IW'(1)) >> 1;
    assign w_kid       = {r_pos[IW-2:0], 1'b1};
    assign w_kid_r     = w_kid + IW'(1);
    assign w_last      = r_count - CW'(1);
    assign w_right_ok  = w_kid_r < w_cnt_x;
    // on equal children the left one wins
    assign w_take_r    = w_right_ok && (i_mem_rdata_a > i_mem_rdata_b);
    assign w_child     = w_take_r ? i_mem_rdata_b : i_mem_rdata_a;
    assign w_child_idx = w_take_r ? w_kid_r : w_kid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_key  <= n_key;
        r_root <= n_root;
    end

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_pos         = r_pos;
        n_key         = r_key;
        n_root        = r_root;
        o_mem_we      = 1'b0;
        o_mem_waddr   = '0;
        o_mem_wdata   = r_key;
        o_mem_raddr_a = '0;
        o_mem_raddr_b = '0;
        o_rsp         = '{valid: 1'b0, key: '0, status: ST_OK};

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_operation)
                        OP_PUSH: begin
                            if (r_count >= CW'(CAPACITY)) begin
                                o_rsp = '{valid: 1'b1, key: '0, status: ST_FULL};
                            end else begin
                                n_key   = i_key_in;
                                n_pos   = w_cnt_x;
                                n_count = r_count + CW'(1);
                                n_state = S_UP_RD;
                            end
                        end
                        OP_POP: begin
                            if (r_count == '0) begin
                                o_rsp = '{valid: 1'b1, key: '0, status: ST_EMPTY};
                            end else begin
                                o_mem_raddr_b = w_last[AW-1:0];
                                n_state       = S_POP_LD;
                            end
                        end
                        OP_PEEK: begin
                            if (r_count == '0) begin
                                o_rsp = '{valid: 1'b1, key: '0, status: ST_EMPTY};
                            end else begin
                                n_state = S_PEEK_LD;
                            end
                        end
                        default: begin
                            o_rsp = '{valid: 1'b1, key: '0, status: ST_OK};
                        end
                    endcase
                end
            end

            S_UP_RD: begin
                if (r_pos == '0) begin
                    o_mem_we    = 1'b1;
                    o_rsp       = '{valid: 1'b1, key: '0, status: ST_OK};
                    n_state     = S_IDLE;
                end else begin
                    o_mem_raddr_a = w_up[AW-1:0];
                    n_state       = S_UP_CMP;
                end
            end

            S_UP_CMP: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_pos[AW-1:0];
                if (i_mem_rdata_a > r_key) begin
                    // parent drops into the hole
                    o_mem_wdata = i_mem_rdata_a;
                    n_pos       = w_up;
                    n_state     = S_UP_RD;
                end else begin
                    o_rsp   = '{valid: 1'b1, key: '0, status: ST_OK};
                    n_state = S_IDLE;
                end
            end

            S_POP_LD: begin
                n_root  = i_mem_rdata_a;
                n_key   = i_mem_rdata_b;
                n_count = w_last;
                n_pos   = '0;
                if (w_last == '0) begin
                    o_rsp   = '{valid: 1'b1, key: i_mem_rdata_a, status: ST_OK};
                    n_state = S_IDLE;
                end else begin
                    n_state = S_DN_RD;
                end
            end

            S_DN_RD: begin
                if (w_kid >= w_cnt_x) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_pos[AW-1:0];
                    o_rsp       = '{valid: 1'b1, key: r_root, status: ST_OK};
                    n_state     = S_IDLE;
                end else begin
                    o_mem_raddr_a = w_kid[AW-1:0];
                    if (w_right_ok) begin
                        o_mem_raddr_b = w_kid_r[AW-1:0];
                    end
                    n_state = S_DN_CMP;
                end
            end

            S_DN_CMP: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_pos[AW-1:0];
                if (r_key > w_child) begin
                    o_mem_wdata = w_child;
                    n_pos       = w_child_idx;
                    n_state     = S_DN_RD;
                end else begin
                    o_rsp   = '{valid: 1'b1, key: r_root, status: ST_OK};
                    n_state = S_IDLE;
                end
            end

            S_PEEK_LD: begin
                o_rsp   = '{valid: 1'b1, key: i_mem_rdata_a, status: ST_OK};
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_count_next = n_count;

endmodule

`default_nettype wire

// File: src/binary_min_heap_top.sv
// ----------------------------------------------------------------------------
// binary_min_heap_top
// Fixed-capacity min-heap priority queue of signed 32-bit keys.
// ----------------------------------------------------------------------------
// Usage:
//   A command (i_operation, i_key_in) transfers at a rising edge with start
//   high and busy low. Operations: push, pop, peek; code 3 is a no-op.
//   Exactly one result follows each command: o_result_valid is high for one
//   cycle with o_key_out, o_status and o_entry_count (count after the op).
//   The receiver cannot stall; results must be taken in that cycle.
// Sequencing (the sift moves a key at most log2 of CAPACITY levels):
//   error status or no-op : busy stays low, result in the cycle after transfer
//   peek                  : busy in S_PEEK_LD only, as the root is read out
//   push                  : an S_UP_RD, S_UP_CMP pair per level moved; ends in
//                           S_UP_RD if the key reaches the root, else S_UP_CMP
//   pop                   : S_POP_LD, then, unless that empties the heap, an
//                           S_DN_RD, S_DN_CMP pair per level moved
//   The result strobe comes in the first cycle with busy low; a new command
//   may transfer in that same cycle. Each level of the sift loop takes a
//   key store read state and a compare and write back state.
// Reset empties the heap at once (entry count to zero); the key store is
// not cleared, as only entries below the count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_min_heap_top
    import bmh_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [1:0]              i_operation,
    input  wire logic signed [KEY_W-1:0] i_key_in,
    output logic                         o_result_valid,
    output logic signed [KEY_W-1:0]      o_key_out,
    output logic [1:0]                   o_status,
    output logic [10:0]                  o_entry_count
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic                    w_we;
    logic [AW-1:0]           w_waddr;
    logic signed [KEY_W-1:0] w_wdata;
    logic [AW-1:0]           w_raddr_a;
    logic [AW-1:0]           w_raddr_b;
    logic signed [KEY_W-1:0] w_rdata_a;
    logic signed [KEY_W-1:0] w_rdata_b;
    t_rsp                    w_rsp;
    logic [CW-1:0]           w_count_next;
    logic [CW+10:0]          w_count_ext;

    logic                    r_result_valid;
    logic signed [KEY_W-1:0] r_key_out;
    t_status                 r_status;
    logic [10:0]             r_entry_count;

    bmh_ram #(
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    bmh_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_operation   (i_operation),
        .i_key_in      (i_key_in),
        .o_busy        (busy),
        .o_mem_we      (w_we),
        .o_mem_waddr   (w_waddr),
        .o_mem_wdata   (w_wdata),
        .o_mem_raddr_a (w_raddr_a),
        .o_mem_raddr_b (w_raddr_b),
        .i_mem_rdata_a (w_rdata_a),
        .i_mem_rdata_b (w_rdata_b),
        .o_rsp         (w_rsp),
        .o_count_next  (w_count_next)
    );

    // count reported modulo 2048
    assign w_count_ext = {11'b0, w_count_next};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= w_rsp.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rsp.valid) begin
            r_key_out     <= w_rsp.key;
            r_status      <= w_rsp.status;
            r_entry_count <= w_count_ext[10:0];
        end
    end

    assign o_result_valid = r_result_valid;
    assign o_key_out      = r_key_out;
    assign o_status       = r_status;
    assign o_entry_count  = r_entry_count;

endmodule

`default_nettype wire

// File: src/bmh_checker.sv
// ----------------------------------------------------------------------------
// bmh_checker
// Port-level checks on the binary min-heap, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "binary_min_heap_top_assert.svh"

module bmh_checker
    import bmh_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    start,
    input wire logic                    busy,
    input wire logic                    o_result_valid,
    input wire logic signed [KEY_W-1:0] o_key_out,
    input wire logic [1:0]              o_status,
    input wire logic [10:0]             o_entry_count
);

    localparam logic [31:0] CAP_FULL = 32'(CAPACITY);
    localparam logic [10:0] CAP_LOW  = CAP_FULL[10:0];

    logic w_xfer;

    assign w_xfer = start && !busy;

    // every transfer either starts work or answers in the next cycle
    `BMH_ASSERT_NEXT(a_xfer_answered, w_xfer, busy || o_result_valid)

    // no result is shown while a command is still in progress
    `BMH_ASSERT_NOW(a_no_result_busy, busy, !o_result_valid)

    // an empty heap reports no keys and a zero key
    `BMH_ASSERT_NOW(a_empty_status, o_result_valid && (o_status == ST_EMPTY),
        (o_key_out == '0) && (o_entry_count == '0))

    // a full status only comes with the count at capacity
    `BMH_ASSERT_NOW(a_full_status, o_result_valid && (o_status == ST_FULL),
        (o_key_out == '0) && (o_entry_count == CAP_LOW))

endmodule

bind binary_min_heap_top bmh_checker #(
    .CAPACITY (CAPACITY)
) u_bmh_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_key_out      (o_key_out),
    .o_status       (o_status),
    .o_entry_count  (o_entry_count)
);

`default_nettype wire
